>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ARN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ARN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/arn_pkg.sv
package arn_pkg;

    localparam int BUF_DEPTH   = 4096;
    localparam int ADDR_W      = $clog2(BUF_DEPTH);
    localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_W       = 15;
    localparam int CFG_IDX_W   = 1;
    localparam int GAIN_W      = 32;
    localparam int SUM_W       = 2 * SAMPLE_BITS + CNT_W - 2;
    localparam int MS_W        = 2 * SAMPLE_BITS;
    localparam int ROOT_W      = MS_W / 2;
    localparam int SQ_CNT_W    = $clog2(ROOT_W + 1);
    localparam int DIV_NUM_W   = SUM_W;
    localparam int DIV_DEN_W   = SAMPLE_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);
    localparam int ACT_RATIO   = 20;
    localparam int ACT_W       = SAMPLE_BITS + 5;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(64'd1 << SAMPLE_BITS);

    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_READ      = 1'b1;
    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SAMPLE  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CEIL   = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_NORMAL  = 2'd0,
        ST_LIMITED = 2'd1,
        ST_SILENT  = 2'd2
    } t_gain_status;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_GAIN,
        DIV_LIMIT
    } t_div_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_STORE,
        S_PK_START,
        S_PK_RUN,
        S_SQ_START,
        S_SQ_RUN,
        S_MEAN_START,
        S_MEAN_WAIT,
        S_ROOT_START,
        S_ROOT_RUN,
        S_GAIN_START,
        S_GAIN_WAIT,
        S_LIM_START,
        S_LIM_WAIT,
        S_CHECK,
        S_DECIDE,
        S_UNITY,
        S_REPORT,
        S_RD_ADDR,
        S_RD_MUL,
        S_RD_OUT
    } t_state;

    typedef struct packed {
        logic     in_ready;
        logic     store;
        logic     scan_start;
        logic     scan_pass;
        logic     scan_run;
        logic     div_start;
        logic     div_take;
        t_div_sel div_sel;
        logic     sqrt_start;
        logic     sqrt_run;
        logic     mul_chk;
        logic     set_gain;
        logic     set_unity;
        logic     rd_issue;
        logic     rd_mul;
        logic     out_report;
        logic     out_sample;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_op;
        logic item_last;
        logic count_zero;
        logic scan_done;
        logic peak_zero;
        logic act_zero;
        logic rms_zero;
        logic div_busy;
        logic div_done;
        logic sqrt_done;
        logic over_ceiling;
        logic out_free;
    } t_sts;

endpackage

>>> hw/rtl/arn_in_if.sv
interface arn_in_if import arn_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          last_in;

    modport source (output valid, operation, sample_in, last_in, input ready);
    modport sink (input valid, operation, sample_in, last_in, output ready);
endinterface

>>> hw/rtl/arn_out_if.sv
interface arn_out_if import arn_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [GAIN_W-1:0]             gain_out;
    logic [1:0]                    status;
    logic                          last_out;

    modport source (output valid, kind, sample_out, gain_out, status, last_out, input ready);
    modport sink (input valid, kind, sample_out, gain_out, status, last_out, output ready);
endinterface

>>> hw/rtl/arn_div.sv
module arn_div import arn_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    assign shifted = {r_rem, r_q[DIV_NUM_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1))) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_NUM_W-2:0], ge};
            r_rem <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> hw/rtl/arn_datapath.sv
module arn_datapath import arn_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    arn_in_if.sink               i_in,
    arn_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts
);

    logic signed [SAMPLE_BITS-1:0] mem [BUF_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_mem_q;

    logic [CNT_W-1:0]  r_count;
    logic              r_closed;
    logic [ADDR_W-1:0] r_rpos;
    logic [GAIN_W-1:0] r_gain;
    t_gain_status      r_status;
    logic [CFG_W-1:0]  r_target;
    logic [CFG_W-1:0]  r_ceil;

    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic                          r_last;

    logic [CNT_W-1:0]       r_idx;
    logic                   r_pipe;
    logic                   r_pass;
    logic [SAMPLE_BITS-1:0] r_peak;
    logic [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]       r_act;

    logic [MS_W-1:0]     r_ms;
    logic [MS_W-1:0]     r_sq_v;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W+1:0]   r_rem;
    logic [SQ_CNT_W-1:0] r_sq_cnt;

    logic [GAIN_W-1:0]             r_g;
    logic [GAIN_W-1:0]             r_lim;
    logic [GAIN_W+SAMPLE_BITS-1:0] r_chk_prod;

    logic                          r_last_rd;
    logic [GAIN_W+SAMPLE_BITS-1:0] r_rd_prod;
    logic                          r_rd_neg;

    logic                          r_ov;
    logic                          r_okind;
    logic signed [SAMPLE_BITS-1:0] r_osmp;
    logic [GAIN_W-1:0]             r_ogain;
    t_gain_status                  r_ostat;
    logic                          r_olast;

    logic                   accept;
    logic [CNT_W-1:0]       base;
    logic                   wr_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      pos;
    logic [CNT_W-1:0]       pos_inc;
    logic                   pos_last;
    logic [SAMPLE_BITS-1:0] q_mag;
    logic [ACT_W-1:0]       q_scaled;
    logic [MS_W-1:0]        q_sq;
    logic                   scan_valid;
    logic [ROOT_W+3:0]      rem_sh;
    logic [ROOT_W+3:0]      trial;
    logic [ROOT_W+3:0]      rem_diff;
    logic                   sq_ge;
    logic                   sq_done;
    logic [GAIN_W+SAMPLE_BITS-1:0] lim_wide;
    logic [GAIN_W+SAMPLE_BITS-1:0] rnd;
    logic [GAIN_W-1:0]             rsh;
    logic signed [SAMPLE_BITS-1:0] rd_val;
    logic [DIV_NUM_W-1:0]   div_num;
    logic [DIV_DEN_W-1:0]   div_den;
    logic                   div_busy;
    logic                   div_done;
    logic [DIV_NUM_W-1:0]   div_quot;
    logic                   out_free;

    assign accept   = i_in.valid && i_cmd.in_ready;
    assign base     = r_closed ? '0 : r_count;
    assign wr_en    = i_cmd.store && (base < CNT_W'(BUF_DEPTH));
    assign pos      = ({1'b0, r_rpos} >= r_count) ? '0 : r_rpos;
    assign pos_inc  = {1'b0, pos} + 1'b1;
    assign pos_last = pos_inc >= r_count;
    assign rd_addr  = i_cmd.rd_issue ? pos : r_idx[ADDR_W-1:0];
    assign scan_valid = i_cmd.scan_run && (r_idx < r_count);

    assign q_mag    = r_mem_q[SAMPLE_BITS-1] ? (~r_mem_q + 1'b1) : r_mem_q;
    assign q_scaled = ACT_W'(q_mag) * ACT_W'(ACT_RATIO);
    assign q_sq     = q_mag * q_mag;

    assign rem_sh   = {r_rem, r_sq_v[MS_W-1:MS_W-2]};
    assign trial    = {2'b00, r_root, 2'b01};
    assign rem_diff = rem_sh - trial;
    assign sq_ge    = rem_sh >= trial;
    assign sq_done  = r_sq_cnt == SQ_CNT_W'(ROOT_W);

    assign lim_wide = (GAIN_W + SAMPLE_BITS)'(r_ceil) << SAMPLE_BITS;

    assign rnd = r_rd_prod + (GAIN_W + SAMPLE_BITS)'(1 << 15);
    assign rsh = rnd[GAIN_W+15:16];

    always_comb begin
        if (!r_rd_neg) begin
            if (rsh > GAIN_W'((1 << (SAMPLE_BITS - 1)) - 1)) begin
                rd_val = SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
            end else begin
                rd_val = rsh[SAMPLE_BITS-1:0];
            end
        end else begin
            if (rsh > GAIN_W'(1 << (SAMPLE_BITS - 1))) begin
                rd_val = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
            end else begin
                rd_val = ~rsh[SAMPLE_BITS-1:0] + 1'b1;
            end
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_MEAN: begin
                div_num = r_sum;
                div_den = DIV_DEN_W'(r_act);
            end
            DIV_GAIN: begin
                div_num = DIV_NUM_W'(r_target) << SAMPLE_BITS;
                div_den = DIV_DEN_W'(r_root);
            end
            DIV_LIMIT: begin
                div_num = DIV_NUM_W'(r_ceil) << SAMPLE_BITS;
                div_den = r_peak;
            end
            default: begin
                div_num = r_sum;
                div_den = DIV_DEN_W'(r_act);
            end
        endcase
    end

    arn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[base[ADDR_W-1:0]] <= r_smp;
        end
        r_mem_q <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_closed <= 1'b0;
            r_rpos   <= '0;
            r_gain   <= UNITY_GAIN;
            r_status <= ST_SILENT;
            r_target <= CFG_W'(5898);
            r_ceil   <= CFG_W'(29164);
            r_ov     <= 1'b0;
            r_pipe   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET: r_target <= i_cfg_data;
                    CFG_CEIL:   r_ceil   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.store) begin
                r_count  <= wr_en ? base + 1'b1 : base;
                r_closed <= r_last;
                if (r_closed || r_last) begin
                    r_rpos <= '0;
                end
            end
            if (i_cmd.rd_issue) begin
                r_rpos <= pos_last ? '0 : pos_inc[ADDR_W-1:0];
            end
            if (i_cmd.set_unity) begin
                r_gain   <= UNITY_GAIN;
                r_status <= ST_SILENT;
            end
            if (i_cmd.set_gain) begin
                r_gain   <= (r_chk_prod > lim_wide) ? r_lim : r_g;
                r_status <= (r_chk_prod > lim_wide) ? ST_LIMITED : ST_NORMAL;
            end
            if (i_cmd.scan_start) begin
                r_pipe <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_pipe <= scan_valid;
            end
            if (i_cmd.out_report || i_cmd.out_sample) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_smp  <= i_in.sample_in;
            r_last <= i_in.last_in;
        end
        if (i_cmd.scan_start) begin
            r_idx  <= '0;
            r_pass <= i_cmd.scan_pass;
            if (!i_cmd.scan_pass) begin
                r_peak <= '0;
            end else begin
                r_sum <= '0;
                r_act <= '0;
            end
        end else begin
            if (scan_valid) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_pipe) begin
                if (!r_pass) begin
                    if (q_mag > r_peak) begin
                        r_peak <= q_mag;
                    end
                end else if (q_scaled > ACT_W'(r_peak)) begin
                    r_sum <= r_sum + SUM_W'(q_sq);
                    r_act <= r_act + 1'b1;
                end
            end
        end
        if (i_cmd.div_take) begin
            case (i_cmd.div_sel)
                DIV_MEAN:  r_ms  <= div_quot[MS_W-1:0];
                DIV_GAIN:  r_g   <= div_quot[GAIN_W-1:0];
                DIV_LIMIT: r_lim <= div_quot[GAIN_W-1:0];
                default: ;
            endcase
        end
        if (i_cmd.sqrt_start) begin
            r_sq_v   <= r_ms;
            r_root   <= '0;
            r_rem    <= '0;
            r_sq_cnt <= '0;
        end else if (i_cmd.sqrt_run && !sq_done) begin
            r_sq_v   <= {r_sq_v[MS_W-3:0], 2'b00};
            r_rem    <= sq_ge ? rem_diff[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
            r_root   <= {r_root[ROOT_W-2:0], sq_ge};
            r_sq_cnt <= r_sq_cnt + 1'b1;
        end
        if (i_cmd.mul_chk) begin
            r_chk_prod <= r_g * r_peak;
        end
        if (i_cmd.rd_issue) begin
            r_last_rd <= pos_last;
        end
        if (i_cmd.rd_mul) begin
            r_rd_prod <= q_mag * r_gain;
            r_rd_neg  <= r_mem_q[SAMPLE_BITS-1];
        end
        if (i_cmd.out_report) begin
            r_okind <= KIND_REPORT;
            r_osmp  <= '0;
            r_ogain <= r_gain;
            r_ostat <= r_status;
            r_olast <= 1'b0;
        end else if (i_cmd.out_sample) begin
            r_okind <= KIND_SAMPLE;
            r_osmp  <= rd_val;
            r_ogain <= r_gain;
            r_ostat <= r_status;
            r_olast <= r_last_rd;
        end
    end

    assign out_free = !r_ov || o_out.ready;

    assign i_in.ready       = i_cmd.in_ready;
    assign o_out.valid      = r_ov;
    assign o_out.kind       = r_okind;
    assign o_out.sample_out = r_osmp;
    assign o_out.gain_out   = r_ogain;
    assign o_out.status     = r_ostat;
    assign o_out.last_out   = r_olast;

    always_comb begin
        o_sts              = '0;
        o_sts.in_valid     = i_in.valid;
        o_sts.in_op        = i_in.operation;
        o_sts.item_last    = r_last;
        o_sts.count_zero   = r_count == '0;
        o_sts.scan_done    = !r_pipe && (r_idx >= r_count);
        o_sts.peak_zero    = r_peak == '0;
        o_sts.act_zero     = r_act == '0;
        o_sts.rms_zero     = r_root == '0;
        o_sts.div_busy     = div_busy;
        o_sts.div_done     = div_done;
        o_sts.sqrt_done    = sq_done;
        o_sts.over_ceiling = r_chk_prod > lim_wide;
        o_sts.out_free     = out_free;
    end

endmodule

>>> hw/rtl/arn_ctrl.sv
module arn_ctrl import arn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    if (i_sts.in_op == OP_LOAD) begin
                        n_state = S_STORE;
                    end else if (!i_sts.count_zero) begin
                        n_state = S_RD_ADDR;
                    end
                end
            end
            S_STORE:      n_state = i_sts.item_last ? S_PK_START : S_IDLE;
            S_PK_START:   n_state = S_PK_RUN;
            S_PK_RUN: begin
                if (i_sts.scan_done) begin
                    n_state = i_sts.peak_zero ? S_UNITY : S_SQ_START;
                end
            end
            S_SQ_START:   n_state = S_SQ_RUN;
            S_SQ_RUN: begin
                if (i_sts.scan_done) begin
                    n_state = i_sts.act_zero ? S_UNITY : S_MEAN_START;
                end
            end
            S_MEAN_START: n_state = S_MEAN_WAIT;
            S_MEAN_WAIT:  n_state = i_sts.div_done ? S_ROOT_START : S_MEAN_WAIT;
            S_ROOT_START: n_state = S_ROOT_RUN;
            S_ROOT_RUN: begin
                if (i_sts.sqrt_done) begin
                    n_state = i_sts.rms_zero ? S_UNITY : S_GAIN_START;
                end
            end
            S_GAIN_START: n_state = S_GAIN_WAIT;
            S_GAIN_WAIT:  n_state = i_sts.div_done ? S_LIM_START : S_GAIN_WAIT;
            S_LIM_START:  n_state = S_LIM_WAIT;
            S_LIM_WAIT:   n_state = i_sts.div_done ? S_CHECK : S_LIM_WAIT;
            S_CHECK:      n_state = S_DECIDE;
            S_DECIDE:     n_state = S_REPORT;
            S_UNITY:      n_state = S_REPORT;
            S_REPORT:     n_state = i_sts.out_free ? S_IDLE : S_REPORT;
            S_RD_ADDR:    n_state = S_RD_MUL;
            S_RD_MUL:     n_state = S_RD_OUT;
            S_RD_OUT:     n_state = i_sts.out_free ? S_IDLE : S_RD_OUT;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_MEAN;
        case (r_state)
            S_IDLE:       o_cmd.in_ready = 1'b1;
            S_STORE:      o_cmd.store = 1'b1;
            S_PK_START:   o_cmd.scan_start = 1'b1;
            S_PK_RUN:     o_cmd.scan_run = 1'b1;
            S_SQ_START: begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_pass  = 1'b1;
            end
            S_SQ_RUN:     o_cmd.scan_run = 1'b1;
            S_MEAN_START: o_cmd.div_start = 1'b1;
            S_MEAN_WAIT:  o_cmd.div_take = i_sts.div_done;
            S_ROOT_START: o_cmd.sqrt_start = 1'b1;
            S_ROOT_RUN:   o_cmd.sqrt_run = 1'b1;
            S_GAIN_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_GAIN;
            end
            S_GAIN_WAIT: begin
                o_cmd.div_take = i_sts.div_done;
                o_cmd.div_sel  = DIV_GAIN;
            end
            S_LIM_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_LIMIT;
            end
            S_LIM_WAIT: begin
                o_cmd.div_take = i_sts.div_done;
                o_cmd.div_sel  = DIV_LIMIT;
            end
            S_CHECK:      o_cmd.mul_chk = 1'b1;
            S_DECIDE:     o_cmd.set_gain = 1'b1;
            S_UNITY:      o_cmd.set_unity = 1'b1;
            S_REPORT:     o_cmd.out_report = i_sts.out_free;
            S_RD_ADDR:    o_cmd.rd_issue = 1'b1;
            S_RD_MUL:     o_cmd.rd_mul = 1'b1;
            S_RD_OUT:     o_cmd.out_sample = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

>>> hw/rtl/active_rms_normalizer.sv
// Gated RMS normalizer with peak ceiling.
// Input channel i_in: operation 0 stores sample_in at the end of the buffer
// (up to 4096 samples); last_in closes the set and starts the measurement.
// Operation 1 reads the next stored sample back, scaled by the current gain.
// Output channel o_out: a gain report (kind 0) after each closing load, or
// a scaled sample (kind 1) per readout. Configuration writes on i_cfg_*
// set the target RMS (index 0) and the peak ceiling (index 1).
// One item is in work at a time; i_in.ready is high only when idle.
// A plain load is written in S_STORE; a readout passes S_RD_ADDR, S_RD_MUL
// and S_RD_OUT to its result. A closing load measures its N samples with two
// passes over the sample memory (one read port, one sample per cycle), up to
// three 43-step runs of the bit-serial divider and a 16-step square root.
// The result waits in an output register while o_out.ready is low; the next
// input transfer is taken meanwhile, and its result holds until the register
// frees. Reset empties the buffer, sets unity gain with silent status and
// the default target and ceiling; memory contents are left as they are.
module active_rms_normalizer import arn_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    arn_in_if.sink               i_in,
    arn_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

`include "assert_macros.svh"

    t_cmd cmd;
    t_sts sts;

    arn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    arn_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

    `ARN_ASSERT_IMP(a_out_free, i_clk, i_rst_n, cmd.out_report || cmd.out_sample, sts.out_free)
    `ARN_ASSERT_IMP(a_div_idle, i_clk, i_rst_n, cmd.div_start, !sts.div_busy)
    `ARN_ASSERT_IMP(a_report_fmt, i_clk, i_rst_n, o_out.valid && (o_out.kind == KIND_REPORT), (o_out.last_out == 1'b0) && (o_out.sample_out == '0))
    `ARN_ASSERT_NXT(a_sample_out, i_clk, i_rst_n, cmd.out_sample, o_out.valid && (o_out.kind == KIND_SAMPLE))

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import arn_pkg::*;

    typedef struct {
        logic                          op;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          lst;
    } t_item;

    typedef struct {
        logic                          kind;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic [GAIN_W-1:0]             gain;
        logic [1:0]                    status;
        logic                          lst;
    } t_result;

    localparam int LIMIT_CYCLES = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_TARGET;
    logic [CFG_W-1:0] i_cfg_data = '0;

    arn_in_if in_ch ();
    arn_out_if out_ch ();

    active_rms_normalizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic signed [SAMPLE_BITS-1:0] store_mem [BUF_DEPTH];
    int unsigned n_stored;
    int unsigned rd_pos;
    bit closed;
    logic [GAIN_W-1:0] gain_q;
    t_gain_status status_q;
    int unsigned target_q;
    int unsigned ceil_q;

    t_item pending[$];
    t_result expected_q[$];
    int fail_cnt = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 0;
    bit in_taken = 0;
    longint cycles = 0;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned magnitude(logic signed [SAMPLE_BITS-1:0] x);
        longint signed sx = x;
        return (sx < 0) ? longint'(-sx) : longint'(sx);
    endfunction

    function automatic void measure_set();
        longint unsigned peak = 0, sumsq = 0, act = 0, a, rms, g, lim;
        for (int i = 0; i < n_stored; i++) begin
            a = magnitude(store_mem[i]);
            if (a > peak) peak = a;
        end
        gain_q = UNITY_GAIN;
        status_q = ST_SILENT;
        if (peak == 0) return;
        for (int i = 0; i < n_stored; i++) begin
            a = magnitude(store_mem[i]);
            if (a * 20 > peak) begin
                sumsq += a * a;
                act++;
            end
        end
        if (act == 0) return;
        rms = floor_sqrt(sumsq / act);
        if (rms == 0) return;
        g = (longint'(target_q) << SAMPLE_BITS) / rms;
        lim = longint'(ceil_q) << SAMPLE_BITS;
        status_q = ST_NORMAL;
        if (g > lim / peak || g * peak > lim) begin
            g = lim / peak;
            status_q = ST_LIMITED;
        end
        gain_q = (g > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : g[31:0];
    endfunction

    function automatic bit normalize_step(t_item it, output t_result res);
        longint unsigned r;
        longint signed v;
        logic signed [SAMPLE_BITS-1:0] x;
        int unsigned p;
        res = '{default: '0};
        if (it.op == OP_LOAD) begin
            if (closed) begin
                n_stored = 0;
                rd_pos = 0;
                closed = 0;
            end
            if (n_stored < BUF_DEPTH) begin
                store_mem[n_stored] = it.smp;
                n_stored++;
            end
            if (!it.lst) return 0;
            measure_set();
            closed = 1;
            rd_pos = 0;
            res.kind = KIND_REPORT;
            res.gain = gain_q;
            res.status = status_q;
            return 1;
        end
        if (n_stored == 0) return 0;
        p = (rd_pos >= n_stored) ? 0 : rd_pos;
        x = store_mem[p];
        r = (magnitude(x) * gain_q + 64'h8000) >> 16;
        if (r > (64'd1 << 40)) r = 64'd1 << 40;
        v = (x < 0) ? -longint'(r) : longint'(r);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        res.kind = KIND_SAMPLE;
        res.smp = v[15:0];
        res.gain = gain_q;
        res.status = status_q;
        res.lst = (p + 1 >= n_stored);
        rd_pos = res.lst ? 0 : p + 1;
        return 1;
    endfunction

    // input side: predict on each accepted transfer
    always @(posedge i_clk) begin
        t_item it;
        t_result res;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
        in_taken = in_ch.valid && in_ch.ready;
        if (i_rst_n && in_taken) begin
            it.op = in_ch.operation;
            it.smp = in_ch.sample_in;
            it.lst = in_ch.last_in;
            if (normalize_step(it, res)) expected_q.push_back(res);
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_item it;
        if (i_rst_n && (!in_ch.valid || in_taken)) begin
            if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pending.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.operation <= it.op;
                in_ch.sample_in <= it.smp;
                in_ch.last_in <= it.lst;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off
    always @(negedge i_clk) begin
        int hold_left;
        if (hold_req) begin
            hold_req = 0;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer");
                fail_cnt++;
            end else begin
                e = expected_q.pop_front();
                if (out_ch.kind !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, out_ch.kind);
                    fail_cnt++;
                end
                if (out_ch.sample_out !== e.smp) begin
                    $error("sample_out: expected %0d, got %0d", e.smp, out_ch.sample_out);
                    fail_cnt++;
                end
                if (out_ch.gain_out !== e.gain) begin
                    $error("gain_out: expected %0d, got %0d", e.gain, out_ch.gain_out);
                    fail_cnt++;
                end
                if (out_ch.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, out_ch.status);
                    fail_cnt++;
                end
                if (out_ch.last_out !== e.lst) begin
                    $error("last_out: expected %0d, got %0d", e.lst, out_ch.last_out);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic add_item(logic op, logic signed [15:0] s, logic l);
        t_item it;
        it.op = op;
        it.smp = s;
        it.lst = l;
        pending.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending.size() > 0 || in_ch.valid || expected_q.size() > 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        if (idx == CFG_TARGET) target_q = val;
        else ceil_q = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_sample();
        int unsigned c = $urandom_range(99);
        logic signed [15:0] s = 16'($urandom);
        if (c < 5) return '0;
        if (c < 8) return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
        return s >>> $urandom_range(15);
    endfunction

    task automatic add_random_set(int len, ref int count);
        bit quiet = ($urandom_range(9) == 0);
        int nrd;
        for (int i = 0; i < len; i++) begin
            add_item(OP_LOAD, quiet ? 16'sd0 : rand_sample(), i == len - 1);
            if ($urandom_range(19) == 0) add_item(OP_READ, 16'($urandom), 1'($urandom));
            count++;
        end
        nrd = $urandom_range(0, (len > 30 ? 8 : len + 3));
        for (int i = 0; i < nrd; i++) add_item(OP_READ, 16'($urandom), 1'($urandom));
        count += nrd;
    endtask

    initial begin
        int count;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_LOAD;
        in_ch.sample_in = '0;
        in_ch.last_in = 1'b0;
        out_ch.ready = 1'b0;
        n_stored = 0;
        rd_pos = 0;
        closed = 0;
        gain_q = UNITY_GAIN;
        status_q = ST_SILENT;
        target_q = 5898;
        ceil_q = 29164;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        add_item(OP_READ, 16'sd0, 1'b0);
        add_item(OP_LOAD, 16'sh7FFF, 1'b0);
        add_item(OP_LOAD, 16'sh8000, 1'b0);
        add_item(OP_LOAD, 16'sd0, 1'b0);
        add_item(OP_LOAD, 16'sd1, 1'b0);
        add_item(OP_LOAD, -16'sd1, 1'b1);
        for (int i = 0; i < 6; i++) add_item(OP_READ, 16'sd0, 1'b1);
        add_item(OP_LOAD, 16'sd0, 1'b0);
        add_item(OP_LOAD, 16'sd0, 1'b1);
        add_item(OP_READ, 16'sd0, 1'b0);
        add_item(OP_LOAD, 16'sd100, 1'b0);
        add_item(OP_LOAD, 16'sd4, 1'b0);
        add_item(OP_READ, 16'sd0, 1'b0);
        add_item(OP_LOAD, -16'sd3, 1'b1);
        add_item(OP_READ, 16'sd0, 1'b0);
        add_item(OP_READ, 16'sd0, 1'b0);
        wait_drained();
        write_reg(CFG_TARGET, 32767);
        write_reg(CFG_CEIL, 0);
        add_item(OP_LOAD, 16'sd1000, 1'b0);
        add_item(OP_LOAD, -16'sd900, 1'b1);
        add_item(OP_READ, 16'sd0, 1'b0);
        wait_drained();
        write_reg(CFG_TARGET, 0);
        write_reg(CFG_CEIL, 32767);
        add_item(OP_LOAD, 16'sd1, 1'b1);
        add_item(OP_READ, 16'sd0, 1'b0);
        wait_drained();

        // random phases
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 66 : 0;
            recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 23 : 0;
            write_reg(CFG_TARGET, (ph == 2) ? 32767 : $urandom_range(0, 32767));
            write_reg(CFG_CEIL, (ph == 2) ? 32767 : $urandom_range(0, 32767));
            count = 0;
            if (ph == 2) begin
                hold_req = 1;
            end
            while (count < 400) begin
                add_random_set($urandom_range(1, 30), count);
                if (pending.size() > 100) wait (pending.size() < 20);
            end
            wait_drained();
        end

        if (fail_cnt == 0 && expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
